[hdl/greedy_graph_coloring_unit_assert.svh]
// Assertion macros shared by the graph coloring RTL.
// No dependencies; included by modules that carry checks.
`ifndef GREEDY_GRAPH_COLORING_UNIT_ASSERT_SVH
`define GREEDY_GRAPH_COLORING_UNIT_ASSERT_SVH

// same-cycle implication
`define GGC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GGC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ggc_pkg.sv]
// Types, constants and helpers for the greedy graph coloring unit.
// No dependencies; used by ggc_seq and the top level.
package ggc_pkg;

    localparam int MAX_VERTICES_DEF = 32;
    localparam int VERTEX_W         = 5;
    localparam int COLOR_W          = 5;
    localparam int COUNT_W          = 6;
    localparam int MASK_W           = 32;
    localparam int COLORABLE_MAX    = 32;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd32;

    typedef enum logic {
        CMD_EDGE  = 1'b0,
        CMD_START = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd                cmd;
        logic [VERTEX_W-1:0] vertex_a;
        logic [VERTEX_W-1:0] vertex_b;
    } t_in_word;

    typedef struct packed {
        logic [VERTEX_W-1:0] vertex;
        logic [COLOR_W-1:0]  color;
        logic                last;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EDGE_A,
        S_EDGE_B,
        S_ROW,
        S_SCAN,
        S_PICK
    } t_state;

    // priority encode the first clear bit; a full mask gives the top color
    function automatic logic [COLOR_W-1:0] lowest_free(input logic [MASK_W-1:0] mask);
        logic [COLOR_W-1:0] res;
        res = COLOR_W'(MASK_W - 1);
        for (int c = MASK_W - 1; c >= 0; c--) begin
            if (!mask[c]) begin
                res = COLOR_W'(c);
            end
        end
        return res;
    endfunction

endpackage

[hdl/ggc_ram.sv]
// Generic simple dual port RAM, one write and one registered read per cycle.
// No dependencies.
module ggc_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]        o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/ggc_adj_store.sv]
// Adjacency bit matrix: one row per vertex in a RAM, per-row valid flags
// so that reset clears the graph at once. Depends on ggc_ram.
module ggc_adj_store #(
    parameter int MAX_VERTICES = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_rd_en,
    input  logic [$clog2(MAX_VERTICES)-1:0] i_rd_addr,
    input  logic                            i_wr_en,
    input  logic [$clog2(MAX_VERTICES)-1:0] i_wr_addr,
    input  logic [MAX_VERTICES-1:0]         i_wr_data,
    output logic [MAX_VERTICES-1:0]         o_row
);

    logic [MAX_VERTICES-1:0] r_valid;
    logic [MAX_VERTICES-1:0] n_valid;
    logic                    r_rd_valid;
    logic [MAX_VERTICES-1:0] ram_data;

    ggc_ram #(
        .DATA_W (MAX_VERTICES),
        .DEPTH  (MAX_VERTICES)
    ) u_rows (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (i_wr_data),
        .i_rd_en   (i_rd_en),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (ram_data)
    );

    always_comb begin
        n_valid = r_valid;
        if (i_wr_en) begin
            n_valid[i_wr_addr] = 1'b1;
        end
    end

    // valid flag sampled with the read, so a same-cycle write to a fresh row
    // cannot expose stale RAM contents
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_row = r_rd_valid ? ram_data : '0;

endmodule

[hdl/ggc_seq.sv]
// Sequencer: edge insertion by read-modify-write of two adjacency rows, and
// the first-fit coloring walk over a color RAM. Depends on ggc_pkg, ggc_ram.
`include "greedy_graph_coloring_unit_assert.svh"

module ggc_seq #(
    parameter int MAX_VERTICES = ggc_pkg::MAX_VERTICES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  ggc_pkg::t_in_word                i_item,
    input  logic [ggc_pkg::COUNT_W-1:0]      i_vertex_count,
    output logic                             o_result_strobe,
    output ggc_pkg::t_out_word               o_result,
    output logic                             o_adj_rd_en,
    output logic [$clog2(MAX_VERTICES)-1:0]  o_adj_rd_addr,
    output logic                             o_adj_wr_en,
    output logic [$clog2(MAX_VERTICES)-1:0]  o_adj_wr_addr,
    output logic [MAX_VERTICES-1:0]          o_adj_wr_data,
    input  logic [MAX_VERTICES-1:0]          i_adj_row
);

    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int NV    = (MAX_VERTICES < ggc_pkg::COLORABLE_MAX) ?
                           MAX_VERTICES : ggc_pkg::COLORABLE_MAX;
    localparam int CW    = $clog2(NV);
    localparam int CNT_W = ggc_pkg::COUNT_W;
    localparam int CLR_W = ggc_pkg::COLOR_W;
    localparam int MSK_W = ggc_pkg::MASK_W;
    localparam int VTX_W = ggc_pkg::VERTEX_W;

    ggc_pkg::t_state   r_state, n_state;
    logic [CW-1:0]     r_u, n_u;
    logic [CW-1:0]     r_j, n_j;
    logic [CW-1:0]     r_last_u, n_last_u;
    logic [NV-1:0]     r_row, n_row;
    logic [MSK_W-1:0]  r_mask, n_mask;
    logic [AW-1:0]     r_a, n_a;
    logic [AW-1:0]     r_b, n_b;

    logic [CNT_W-1:0]  sat_count;
    logic              edge_ok;
    logic [CLR_W-1:0]  pick_color;
    logic              col_rd_en;
    logic [CW-1:0]     col_rd_addr;
    logic              col_wr_en;
    logic [CLR_W-1:0]  col_rd_data;

    ggc_ram #(
        .DATA_W (CLR_W),
        .DEPTH  (NV)
    ) u_colors (
        .i_clk     (i_clk),
        .i_wr_en   (col_wr_en),
        .i_wr_addr (r_u),
        .i_wr_data (pick_color),
        .i_rd_en   (col_rd_en),
        .i_rd_addr (col_rd_addr),
        .o_rd_data (col_rd_data)
    );

    assign sat_count  = (i_vertex_count > CNT_W'(NV)) ? CNT_W'(NV) : i_vertex_count;
    assign edge_ok    = (32'(i_item.vertex_a) < MAX_VERTICES) &&
                        (32'(i_item.vertex_b) < MAX_VERTICES);
    assign pick_color = ggc_pkg::lowest_free(r_mask);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ggc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u      <= n_u;
        r_j      <= n_j;
        r_last_u <= n_last_u;
        r_row    <= n_row;
        r_mask   <= n_mask;
        r_a      <= n_a;
        r_b      <= n_b;
    end

    always_comb begin
        n_state         = r_state;
        n_u             = r_u;
        n_j             = r_j;
        n_last_u        = r_last_u;
        n_row           = r_row;
        n_mask          = r_mask;
        n_a             = r_a;
        n_b             = r_b;
        o_adj_rd_en     = 1'b0;
        o_adj_rd_addr   = '0;
        o_adj_wr_en     = 1'b0;
        o_adj_wr_addr   = '0;
        o_adj_wr_data   = '0;
        col_rd_en       = 1'b0;
        col_rd_addr     = '0;
        col_wr_en       = 1'b0;
        o_result_strobe = 1'b0;
        o_busy          = (r_state != ggc_pkg::S_IDLE);

        unique case (r_state)
            ggc_pkg::S_IDLE: begin
                if (i_start) begin
                    if (i_item.cmd == ggc_pkg::CMD_EDGE) begin
                        if (edge_ok) begin
                            n_a           = AW'(i_item.vertex_a);
                            n_b           = AW'(i_item.vertex_b);
                            o_adj_rd_en   = 1'b1;
                            o_adj_rd_addr = AW'(i_item.vertex_a);
                            n_state       = ggc_pkg::S_EDGE_A;
                        end
                    end else if (sat_count != '0) begin
                        n_last_u      = CW'(sat_count - CNT_W'(1));
                        n_u           = '0;
                        o_adj_rd_en   = 1'b1;
                        o_adj_rd_addr = '0;
                        n_state       = ggc_pkg::S_ROW;
                    end
                end
            end
            ggc_pkg::S_EDGE_A: begin
                o_adj_wr_en   = 1'b1;
                o_adj_wr_addr = r_a;
                o_adj_wr_data = i_adj_row | (MAX_VERTICES'(1) << r_b);
                o_adj_rd_en   = 1'b1;
                o_adj_rd_addr = r_b;
                n_state       = ggc_pkg::S_EDGE_B;
            end
            ggc_pkg::S_EDGE_B: begin
                // a self loop reads the row before the first write; both
                // writes set the same bit, so nothing is lost
                o_adj_wr_en   = 1'b1;
                o_adj_wr_addr = r_b;
                o_adj_wr_data = i_adj_row | (MAX_VERTICES'(1) << r_a);
                n_state       = ggc_pkg::S_IDLE;
            end
            ggc_pkg::S_ROW: begin
                n_row  = i_adj_row[NV-1:0];
                n_mask = '0;
                n_j    = '0;
                if (r_u == '0) begin
                    n_state = ggc_pkg::S_PICK;
                end else begin
                    col_rd_en   = 1'b1;
                    col_rd_addr = '0;
                    n_state     = ggc_pkg::S_SCAN;
                end
            end
            ggc_pkg::S_SCAN: begin
                // col_rd_data is the color of neighbor candidate r_j
                if (r_row[r_j]) begin
                    n_mask = r_mask | (MSK_W'(1) << col_rd_data);
                end
                if (r_j == r_u - CW'(1)) begin
                    n_state = ggc_pkg::S_PICK;
                end else begin
                    n_j         = r_j + CW'(1);
                    col_rd_en   = 1'b1;
                    col_rd_addr = r_j + CW'(1);
                end
            end
            ggc_pkg::S_PICK: begin
                col_wr_en       = 1'b1;
                o_result_strobe = 1'b1;
                if (r_u == r_last_u) begin
                    n_state = ggc_pkg::S_IDLE;
                end else begin
                    n_u           = r_u + CW'(1);
                    o_adj_rd_en   = 1'b1;
                    o_adj_rd_addr = AW'(r_u + CW'(1));
                    n_state       = ggc_pkg::S_ROW;
                end
            end
            default: begin
                n_state = ggc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_result.vertex = VTX_W'(r_u);
        o_result.color  = pick_color;
        o_result.last   = (r_u == r_last_u);
    end

    `GGC_ASSERT_NEXT(a_last_ends_run, i_clk, i_rst_n, o_result_strobe && o_result.last, !o_busy, "run did not end after last word")
    `GGC_ASSERT_NEXT(a_result_gap, i_clk, i_rst_n, o_result_strobe && !o_result.last, !o_result_strobe && o_busy, "back-to-back result words")
    `GGC_ASSERT_NOW(a_adj_write_edge, i_clk, i_rst_n, o_adj_wr_en, (r_state == ggc_pkg::S_EDGE_A) || (r_state == ggc_pkg::S_EDGE_B), "adjacency written outside edge insert")
    `GGC_ASSERT_NOW(a_scan_lower, i_clk, i_rst_n, r_state == ggc_pkg::S_SCAN, (r_j < r_u) && (r_u <= r_last_u), "scan index out of order")

endmodule

[hdl/greedy_graph_coloring_unit.sv]
// Greedy first-fit graph coloring unit, top level.
// An edge word (cmd = edge) keeps busy high while both adjacency rows are
// read and rewritten; endpoints at or above MAX_VERTICES are dropped at once.
// A start word colors vertices 0 to n-1, n = min(vertex_count, MAX_VERTICES,
// 32), and returns one result word per vertex on o_result with
// o_result_strobe high for a single cycle; the receiver cannot stall it, so
// it must take every strobed word. Each vertex u needs one row read, one color
// RAM read per lower vertex and one pick, so results arrive spaced apart and
// later vertices take longer; the single read port of the color RAM sets this.
// The graph is cleared at reset without a sweep and is kept across runs.
// vertex_count is written through the cfg channel, which is ready while the
// block is not busy.
module greedy_graph_coloring_unit #(
    parameter int MAX_VERTICES = ggc_pkg::MAX_VERTICES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  ggc_pkg::t_in_word           i_item,
    output logic                        o_result_strobe,
    output ggc_pkg::t_out_word          o_result,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [ggc_pkg::COUNT_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_VERTICES);

    logic [ggc_pkg::COUNT_W-1:0] r_vertex_count;
    logic [ggc_pkg::COUNT_W-1:0] n_vertex_count;

    logic                    adj_rd_en;
    logic [AW-1:0]           adj_rd_addr;
    logic                    adj_wr_en;
    logic [AW-1:0]           adj_wr_addr;
    logic [MAX_VERTICES-1:0] adj_wr_data;
    logic [MAX_VERTICES-1:0] adj_row;

    assign o_cfg_ready = !busy;

    always_comb begin
        n_vertex_count = r_vertex_count;
        if (i_cfg_valid && o_cfg_ready) begin
            n_vertex_count = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= ggc_pkg::COUNT_RESET;
        end else begin
            r_vertex_count <= n_vertex_count;
        end
    end

    ggc_adj_store #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_adj (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (adj_rd_en),
        .i_rd_addr (adj_rd_addr),
        .i_wr_en   (adj_wr_en),
        .i_wr_addr (adj_wr_addr),
        .i_wr_data (adj_wr_data),
        .o_row     (adj_row)
    );

    ggc_seq #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .o_busy          (busy),
        .i_item          (i_item),
        .i_vertex_count  (r_vertex_count),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result),
        .o_adj_rd_en     (adj_rd_en),
        .o_adj_rd_addr   (adj_rd_addr),
        .o_adj_wr_en     (adj_wr_en),
        .o_adj_wr_addr   (adj_wr_addr),
        .o_adj_wr_data   (adj_wr_data),
        .i_adj_row       (adj_row)
    );

endmodule
